// ===== rtl/date_bucket_hash_table_assert.svh =====
// assertion macros for the date bucket hash table
// used by the top level, which must provide clk and arst_n
`ifndef DATE_BUCKET_HASH_TABLE_ASSERT_SVH
`define DATE_BUCKET_HASH_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DBHT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define DBHT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DBHT_ASSERT_SAME(lbl, ante, cons, msg)
`define DBHT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/dbht_pkg.sv =====
// shared types and constants of the date bucket hash table
// no dependencies
package dbht_pkg;

	localparam int DAY_W   = 5;
	localparam int MON_W   = 4;
	localparam int KEY_W   = DAY_W + MON_W;
	localparam int NW      = 7;
	localparam int FRAC_W  = 16;
	localparam int LOAD_W  = 17;
	localparam int DIV_W   = NW + FRAC_W;
	localparam int STEP_W  = 5;
	localparam int MATCH_W = 5;

	localparam logic [STEP_W-1:0] HASH_STEPS = STEP_W'(KEY_W);
	localparam logic [STEP_W-1:0] LOAD_STEPS = STEP_W'(DIV_W);

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_QUERY  = 2'd1,
		ACT_OCCUPY = 2'd2,
		ACT_NONE   = 2'd3
	} dbht_action_t;

	typedef struct packed {
		logic              load;
		logic [DIV_W-1:0]  dividend;
		logic [NW-1:0]     divisor;
		logic [STEP_W-1:0] steps;
	} dbht_div_cmd_t;

	typedef struct packed {
		logic             busy;
		logic [DIV_W-1:0] quot;
		logic [NW-1:0]    rem;
	} dbht_div_stat_t;

endpackage

// ===== rtl/dbht_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
module dbht_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/dbht_div.sv =====
// shared restoring divider, one quotient bit per cycle
// serves the bucket hash modulo and the load fraction; uses dbht_pkg
module dbht_div
	import dbht_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  dbht_div_cmd_t  cmd,
	output dbht_div_stat_t stat
);

	logic [DIV_W-1:0]  quo_q;
	logic [NW-1:0]     rem_q;
	logic [NW-1:0]     dvs_q;
	logic [STEP_W-1:0] cnt_q;
	logic [NW:0]       trial;
	logic              ge;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= cmd.steps;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quo_q <= cmd.dividend;
			rem_q <= '0;
			dvs_q <= cmd.divisor;
		end else if (cnt_q != '0) begin
			// trial stays below the divisor when ge is low, so it fits
			rem_q <= ge ? NW'(trial - {1'b0, dvs_q}) : trial[NW-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign stat.busy = cnt_q != '0;
	assign stat.quot = quo_q;
	assign stat.rem  = rem_q;

endmodule

// ===== rtl/date_bucket_hash_table.sv =====
// top level of the date bucket hash table: sequencer, key and fill stores
// uses dbht_pkg, dbht_ram, dbht_div and date_bucket_hash_table_assert.svh
//
// Usage: an item (action, day, month) is taken at a clock edge with start high
// and busy low. Busy stays high until done pulses for one cycle with
// match_count, occupied_buckets, load_fraction and status; the receiver cannot
// stall and must take the result in that cycle. Keys hash to bucket
// (day*month-1) mod n, n being bucket_count clamped to 1..BUCKETS.
// Steps from accept to done, set by the bit-serial divider (one bit a cycle)
// and the single read port of each store:
//   insert      9 divider steps, fill read, write
//   query       9 divider steps, fill read, then one stored key compared a cycle
//   occupancy   one fill word read a cycle for the n buckets, then 23 divider steps
//   other code  straight to done, all fields zero
// A key with day or month zero skips the divider and lands in bucket n-1.
// After reset the fill store is cleared with busy high;
// cfg_ready is always high, and bucket_count resets to 64. Writes of
// bucket_count are meant for idle periods and do not clear the table.
`include "date_bucket_hash_table_assert.svh"

module date_bucket_hash_table
	import dbht_pkg::*;
#(
	parameter int BUCKETS      = 64,
	parameter int BUCKET_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           action,
	input  logic [DAY_W-1:0]     day,
	input  logic [MON_W-1:0]     month,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [NW-1:0]        cfg_data,
	output logic                 done,
	output logic [MATCH_W-1:0]   match_count,
	output logic [NW-1:0]        occupied_buckets,
	output logic [LOAD_W-1:0]    load_fraction,
	output logic                 status
);

	localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int FW  = $clog2(BUCKET_DEPTH + 1);
	localparam int KD  = BUCKETS * BUCKET_DEPTH;
	localparam int KAW = (KD > 1) ? $clog2(KD) : 1;
	localparam int SW  = ((BW > NW) ? BW : NW) + 1;

	typedef enum logic [7:0] {
		S_CLEAR   = 8'b0000_0001,
		S_IDLE    = 8'b0000_0010,
		S_DIV     = 8'b0000_0100,
		S_FILL_RD = 8'b0000_1000,
		S_FILL_WT = 8'b0001_0000,
		S_WALK    = 8'b0010_0000,
		S_OCC     = 8'b0100_0000,
		S_DONE    = 8'b1000_0000
	} state_t;

	state_t             state_q;
	logic [NW-1:0]      bucket_count_q;
	logic [NW-1:0]      n_eff;
	dbht_action_t       act_q;
	logic [KEY_W-1:0]   key_q;
	logic [BW-1:0]      bucket_q;
	logic [KAW-1:0]     base_q;
	logic [FW-1:0]      fill_q;
	logic [FW-1:0]      idx_q;
	logic [SW-1:0]      scan_q;
	logic               cmp_vld_q;
	logic [FW-1:0]      match_q;
	logic [NW-1:0]      occ_q;
	logic [LOAD_W-1:0]  load_q;
	logic               status_q;
	logic [KEY_W-1:0]   prod;
	logic [KEY_W-1:0]   prod_m1;
	logic               hash_op;
	logic               walk_issue;
	logic               occ_issue;
	logic               bucket_full;

	logic               fill_we;
	logic [BW-1:0]      fill_waddr;
	logic [FW-1:0]      fill_wdata;
	logic               fill_re;
	logic [BW-1:0]      fill_raddr;
	logic [FW-1:0]      fill_rd;
	logic               key_we;
	logic [KAW-1:0]     key_waddr;
	logic               key_re;
	logic [KAW-1:0]     key_raddr;
	logic [KEY_W-1:0]   key_rd;

	dbht_div_cmd_t      div_cmd;
	dbht_div_stat_t     div_st;

	// bucket count clamped to 1..BUCKETS
	always_comb begin
		priority if (bucket_count_q == '0) begin
			n_eff = NW'(1);
		end else if (32'(bucket_count_q) > BUCKETS) begin
			n_eff = NW'(BUCKETS);
		end else begin
			n_eff = bucket_count_q;
		end
	end

	assign prod        = KEY_W'(day) * KEY_W'(month);
	assign prod_m1     = prod - 1'b1;
	assign hash_op     = (action == ACT_INSERT) || (action == ACT_QUERY);
	assign walk_issue  = idx_q != fill_q;
	assign occ_issue   = scan_q != SW'(n_eff);
	assign bucket_full = fill_rd >= FW'(BUCKET_DEPTH);

	always_comb begin
		fill_we          = 1'b0;
		fill_waddr       = bucket_q;
		fill_wdata       = FW'(fill_rd + 1'b1);
		fill_re          = 1'b0;
		fill_raddr       = bucket_q;
		key_we           = 1'b0;
		key_waddr        = KAW'(base_q + KAW'(fill_rd));
		key_re           = 1'b0;
		key_raddr        = KAW'(base_q + KAW'(idx_q));
		div_cmd.load     = 1'b0;
		div_cmd.dividend = {prod_m1, {(DIV_W - KEY_W){1'b0}}};
		div_cmd.divisor  = n_eff;
		div_cmd.steps    = HASH_STEPS;
		unique case (state_q)
			S_CLEAR: begin
				fill_we    = 1'b1;
				fill_waddr = BW'(scan_q);
				fill_wdata = '0;
			end
			S_IDLE: begin
				div_cmd.load = start && hash_op && (prod != '0);
			end
			S_FILL_RD: begin
				fill_re = 1'b1;
			end
			S_FILL_WT: begin
				if (act_q == ACT_INSERT && !bucket_full) begin
					fill_we = 1'b1;
					key_we  = 1'b1;
				end
			end
			S_WALK: begin
				key_re = walk_issue;
			end
			S_OCC: begin
				fill_re          = occ_issue;
				fill_raddr       = BW'(scan_q);
				div_cmd.load     = !occ_issue && !cmp_vld_q;
				div_cmd.dividend = {occ_q, {FRAC_W{1'b0}}};
				div_cmd.steps    = LOAD_STEPS;
			end
			S_DIV, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			bucket_count_q <= NW'(64);
			scan_q         <= '0;
		end else begin
			if (cfg_valid) begin
				bucket_count_q <= cfg_data;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (scan_q == SW'(BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
					scan_q <= scan_q + 1'b1;
				end
				S_IDLE: begin
					if (start) begin
						scan_q <= '0;
						unique case (dbht_action_t'(action))
							ACT_INSERT, ACT_QUERY: begin
								state_q <= (prod == '0) ? S_FILL_RD : S_DIV;
							end
							ACT_OCCUPY: state_q <= S_OCC;
							ACT_NONE:   state_q <= S_DONE;
							default:    state_q <= S_DONE;
						endcase
					end
				end
				S_DIV: begin
					if (!div_st.busy) begin
						state_q <= (act_q == ACT_OCCUPY) ? S_DONE : S_FILL_RD;
					end
				end
				S_FILL_RD: state_q <= S_FILL_WT;
				S_FILL_WT: begin
					if (act_q == ACT_QUERY && fill_rd != '0) begin
						state_q <= S_WALK;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_WALK: begin
					if (!walk_issue && !cmp_vld_q) begin
						state_q <= S_DONE;
					end
				end
				S_OCC: begin
					if (occ_issue) begin
						scan_q <= scan_q + 1'b1;
					end else if (!cmp_vld_q) begin
						state_q <= S_DIV;
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				act_q     <= dbht_action_t'(action);
				key_q     <= {month, day};
				bucket_q  <= BW'(n_eff - 1'b1);
				match_q   <= '0;
				occ_q     <= '0;
				load_q    <= '0;
				status_q  <= 1'b0;
				idx_q     <= '0;
				cmp_vld_q <= 1'b0;
			end
			S_DIV: begin
				if (!div_st.busy) begin
					if (act_q == ACT_OCCUPY) begin
						load_q <= LOAD_W'(div_st.quot);
					end else begin
						bucket_q <= BW'(div_st.rem);
					end
				end
			end
			S_FILL_RD: begin
				base_q <= KAW'(bucket_q * BUCKET_DEPTH);
			end
			S_FILL_WT: begin
				fill_q   <= fill_rd;
				status_q <= (act_q == ACT_INSERT) && bucket_full;
			end
			S_WALK: begin
				if (walk_issue) begin
					idx_q <= idx_q + 1'b1;
				end
				cmp_vld_q <= walk_issue;
				if (cmp_vld_q && key_rd == key_q) begin
					match_q <= match_q + 1'b1;
				end
			end
			S_OCC: begin
				cmp_vld_q <= occ_issue;
				if (cmp_vld_q && fill_rd != '0) begin
					occ_q <= occ_q + 1'b1;
				end
			end
			S_CLEAR, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	dbht_ram #(
		.WIDTH (FW),
		.DEPTH (BUCKETS)
	) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.re    (fill_re),
		.raddr (fill_raddr),
		.rdata (fill_rd)
	);

	dbht_ram #(
		.WIDTH (KEY_W),
		.DEPTH (KD)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_q),
		.re    (key_re),
		.raddr (key_raddr),
		.rdata (key_rd)
	);

	dbht_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.stat   (div_st)
	);

	assign busy             = state_q != S_IDLE;
	assign cfg_ready        = 1'b1;
	assign done             = state_q == S_DONE;
	assign match_count      = MATCH_W'(match_q);
	assign occupied_buckets = occ_q;
	assign load_fraction    = load_q;
	assign status           = status_q;

	`DBHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
	`DBHT_ASSERT_NEXT(a_done_pulse, done, !done, "done held longer than one cycle")
	`DBHT_ASSERT_SAME(a_div_idle, div_cmd.load, !div_st.busy, "divider restarted while running")
	`DBHT_ASSERT_SAME(a_full_insert, done && status, act_q == ACT_INSERT, "full status on non insert")

endmodule
